// File: sv/skinning_envelope_blend_unit_assert.svh
// assertion macros used by the envelope blend checker
`ifndef SKINNING_ENVELOPE_BLEND_UNIT_ASSERT_SVH
`define SKINNING_ENVELOPE_BLEND_UNIT_ASSERT_SVH

// consequent must hold in the same cycle
`define SEB_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("envelope blend check failed");

// consequent must hold in the next cycle
`define SEB_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("envelope blend check failed");

`endif

// File: sv/seb_pkg.sv
// types and constants of the skinning envelope blend unit
`timescale 1ns / 1ps
package seb_pkg;

  localparam int WORD_W       = 32;
  localparam int ROW_W        = 4 * WORD_W;
  localparam int WEIGHT_SHIFT = 16;

  // operation codes
  localparam logic [1:0] OP_LOAD_WORLD = 2'd0;
  localparam logic [1:0] OP_LOAD_INV   = 2'd1;
  localparam logic [1:0] OP_MIX        = 2'd2;

  // row and column codes
  localparam logic [1:0] ROW_LAST    = 2'd2;
  localparam logic [1:0] ROW_INVALID = 2'd3;
  localparam logic [1:0] COL_TRANS   = 2'd3;
  localparam logic [1:0] K_LAST      = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         joint_index;
    logic [1:0]         row_index;
    logic signed [31:0] elem_a;
    logic signed [31:0] elem_b;
    logic signed [31:0] elem_c;
    logic signed [31:0] elem_d;
    logic [16:0]        weight;
    logic               uniform_scale;
    logic               last_term;
  } item_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic signed [31:0] out_c;
    logic signed [31:0] out_d;
    logic               envelope_uniform;
    logic               last_row;
  } result_t;

  // clamp a wide signed value to one Q16.16 word
  function automatic logic signed [31:0] sat_word(input logic signed [66:0] v);
    logic signed [66:0] hi;
    logic signed [66:0] lo;
    hi = 67'sh7FFFFFFF;
    lo = -67'sh80000000;
    if (v > hi) begin
      sat_word = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat_word = 32'sh80000000;
    end else begin
      sat_word = v[31:0];
    end
  endfunction

endpackage

// File: sv/seb_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module seb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/skinning_envelope_blend_unit.sv
// top level: skinning envelope blend over row-wide matrix memories
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------
//  item     | item_valid / item_ready    | seb_pkg::item_t
//  result   | result_valid / result_ready| seb_pkg::result_t
//
// a load beat writes one matrix row into one word of a row memory.
// a mix beat holds item_ready low while 36 row-pair reads feed one shared 32x32
// multiplier, the five pipeline stages drain and the term closes.
// a last term then emits three result beats, at best one per cycle, before item_ready returns.
// reset clears control and the accumulator and sets the envelope flag; stores are not cleared.
// a stalled result beat holds its row and blocks the next one.
`timescale 1ns / 1ps
module skinning_envelope_blend_unit #(
  parameter int JOINT_COUNT = 128,
  parameter int FRAC_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  seb_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output seb_pkg::result_t result
);

  localparam int JW        = $clog2(JOINT_COUNT);
  localparam int ROW_DEPTH = JOINT_COUNT * 3;
  localparam int AW        = $clog2(ROW_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_MIX, ST_EMIT} state_t;

  state_t state;

  logic                           accept;
  logic [17:0]                    jwrap;
  logic [JW-1:0]                  jm;
  logic [AW-1:0]                  wr_addr;
  logic [AW-1:0]                  jbase;
  logic                           world_we;
  logic                           inv_we;
  logic                           flag_we;
  logic [seb_pkg::ROW_W-1:0]      row_wdata;
  logic [AW-1:0]                  world_raddr;
  logic [AW-1:0]                  inv_raddr;
  logic [seb_pkg::ROW_W-1:0]      world_rdata;
  logic [seb_pkg::ROW_W-1:0]      inv_rdata;
  logic                           flag_rdata;

  // item registers
  logic [AW-1:0]                  base;
  logic [JW-1:0]                  jreg;
  logic [16:0]                    wgt;
  logic                           last;
  logic                           env;

  // issue counters
  logic                           issuing;
  logic [1:0]                     r_cnt;
  logic [1:0]                     c_cnt;
  logic [1:0]                     k_cnt;

  // pipeline
  logic                           v1, v2, v3, v4, v5;
  logic [3:0]                     idx1, idx2, idx3, idx4, idx5;
  logic [1:0]                     k1, k2;
  logic signed [63:0]             prod;
  logic signed [31:0]             trans2, trans3;
  logic signed [65:0]             sum;
  logic signed [31:0]             elem;
  logic signed [49:0]             term;
  logic signed [31:0]             acc [12];

  logic signed [31:0]             wsel;
  logic signed [31:0]             isel;
  logic signed [65:0]             sum_sh;
  logic signed [66:0]             elem_full;
  logic signed [49:0]             term_sh;
  logic signed [66:0]             acc_full;
  logic                           mix_done;
  logic                           env_mix;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;

  // joint index wrap by binary compare and subtract
  always_comb begin
    jwrap = {11'd0, item.joint_index};
    for (int s = 6; s >= 0; s--) begin
      if (jwrap >= (18'(JOINT_COUNT) << s)) begin
        jwrap = jwrap - (18'(JOINT_COUNT) << s);
      end
    end
  end
  assign jm      = jwrap[JW-1:0];
  assign jbase   = AW'({jm, 1'b0}) + AW'(jm);
  assign wr_addr = jbase + AW'(item.row_index);

  // load writes
  assign row_wdata = {item.elem_d, item.elem_c, item.elem_b, item.elem_a};
  assign world_we  = accept && (item.operation == seb_pkg::OP_LOAD_WORLD) &&
                     (item.row_index != seb_pkg::ROW_INVALID);
  assign inv_we    = accept && (item.operation == seb_pkg::OP_LOAD_INV) &&
                     (item.row_index != seb_pkg::ROW_INVALID);
  assign flag_we   = world_we;

  assign world_raddr = base + AW'(r_cnt);
  assign inv_raddr   = base + AW'(k_cnt);

  seb_ram #(.WIDTH(seb_pkg::ROW_W), .DEPTH(ROW_DEPTH)) u_world (
    .clk   (clk),
    .we    (world_we),
    .waddr (wr_addr),
    .wdata (row_wdata),
    .raddr (world_raddr),
    .rdata (world_rdata)
  );

  seb_ram #(.WIDTH(seb_pkg::ROW_W), .DEPTH(ROW_DEPTH)) u_inverse (
    .clk   (clk),
    .we    (inv_we),
    .waddr (wr_addr),
    .wdata (row_wdata),
    .raddr (inv_raddr),
    .rdata (inv_rdata)
  );

  seb_ram #(.WIDTH(1), .DEPTH(JOINT_COUNT)) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (jm),
    .wdata (item.uniform_scale),
    .raddr (jreg),
    .rdata (flag_rdata)
  );

  // operand select, element finish and weighted term
  assign wsel      = world_rdata[{k1, 5'd0} +: seb_pkg::WORD_W];
  assign isel      = inv_rdata[{idx1[1:0], 5'd0} +: seb_pkg::WORD_W];
  assign sum_sh    = sum >>> FRAC_BITS;
  assign elem_full = 67'(sum_sh) + ((idx3[1:0] == seb_pkg::COL_TRANS) ? 67'(trans3) : 67'sd0);
  assign term_sh   = term >>> seb_pkg::WEIGHT_SHIFT;
  assign acc_full  = 67'(acc[idx5]) + 67'(term_sh);
  assign mix_done  = !issuing && !v1 && !v2 && !v3 && !v4 && !v5;
  assign env_mix   = env & flag_rdata;

  // control, pipeline and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issuing      <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      env          <= 1'b1;
      result_valid <= 1'b0;
      for (int i = 0; i < 12; i++) begin
        acc[i] <= '0;
      end
    end else begin
      // pipeline stages
      v1     <= issuing;
      idx1   <= {r_cnt, c_cnt};
      k1     <= k_cnt;
      v2     <= v1;
      idx2   <= idx1;
      k2     <= k1;
      prod   <= wsel * isel;
      trans2 <= world_rdata[3*seb_pkg::WORD_W +: seb_pkg::WORD_W];
      if (v2) begin
        sum <= ((k2 == 2'd0) ? 66'sd0 : sum) + 66'(prod);
      end
      v3     <= v2 && (k2 == seb_pkg::K_LAST);
      idx3   <= idx2;
      trans3 <= trans2;
      v4     <= v3;
      idx4   <= idx3;
      elem   <= seb_pkg::sat_word(elem_full);
      v5     <= v4;
      idx5   <= idx4;
      term   <= elem * $signed({1'b0, wgt});

      unique case (state)
        ST_IDLE: begin
          if (accept && (item.operation == seb_pkg::OP_MIX)) begin
            state   <= ST_MIX;
            base    <= jbase;
            jreg    <= jm;
            wgt     <= item.weight;
            last    <= item.last_term;
            issuing <= 1'b1;
            r_cnt   <= 2'd0;
            c_cnt   <= 2'd0;
            k_cnt   <= 2'd0;
          end
        end
        ST_MIX: begin
          // walk rows, columns and inner index
          if (issuing) begin
            if (k_cnt == seb_pkg::K_LAST) begin
              k_cnt <= 2'd0;
              if (c_cnt == seb_pkg::COL_TRANS) begin
                c_cnt <= 2'd0;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == seb_pkg::ROW_LAST) begin
                  issuing <= 1'b0;
                end
              end else begin
                c_cnt <= c_cnt + 2'd1;
              end
            end else begin
              k_cnt <= k_cnt + 2'd1;
            end
          end
          if (v5) begin
            acc[idx5] <= seb_pkg::sat_word(acc_full);
          end
          if (mix_done) begin
            env <= env_mix;
            if (last) begin
              state                   <= ST_EMIT;
              result_valid            <= 1'b1;
              result.out_row          <= 2'd0;
              result.out_a            <= acc[0];
              result.out_b            <= acc[1];
              result.out_c            <= acc[2];
              result.out_d            <= acc[3];
              result.envelope_uniform <= env_mix;
              result.last_row         <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                acc[i] <= acc[i+4];
              end
              for (int i = 8; i < 12; i++) begin
                acc[i] <= '0;
              end
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          // hand out rows; the accumulator shifts down and clears behind
          if (result_ready) begin
            if (result.out_row == seb_pkg::ROW_LAST) begin
              result_valid <= 1'b0;
              env          <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              result.out_row  <= result.out_row + 2'd1;
              result.out_a    <= acc[0];
              result.out_b    <= acc[1];
              result.out_c    <= acc[2];
              result.out_d    <= acc[3];
              result.last_row <= (result.out_row + 2'd1 == seb_pkg::ROW_LAST);
              for (int i = 0; i < 8; i++) begin
                acc[i] <= acc[i+4];
              end
              for (int i = 8; i < 12; i++) begin
                acc[i] <= '0;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/seb_check.sv
// port checker for the skinning envelope blend unit, with its bind
`timescale 1ns / 1ps
`include "skinning_envelope_blend_unit_assert.svh"
module seb_check (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input seb_pkg::result_t result
);

  logic out_stall;
  logic out_beat;
  logic row_is_last;

  assign out_stall   = result_valid && !result_ready;
  assign out_beat    = result_valid && result_ready;
  assign row_is_last = (result.out_row == seb_pkg::ROW_LAST);

  // stalled result beat holds
  `SEB_ASSERT_NEXT(a_hold, clk, rst, out_stall, result_valid && $stable(result))
  // row code stays in range
  `SEB_ASSERT_NOW(a_row, clk, rst, result_valid, result.out_row != seb_pkg::ROW_INVALID)
  // last row flag marks row two only
  `SEB_ASSERT_NOW(a_last, clk, rst, result_valid, result.last_row == row_is_last)
  // row zero is followed at once by row one
  `SEB_ASSERT_NEXT(a_seq, clk, rst, out_beat && (result.out_row == 2'd0), result.out_row == 2'd1)
  // no item is taken while results are out
  `SEB_ASSERT_NOW(a_block, clk, rst, result_valid, !item_ready)

endmodule

bind skinning_envelope_blend_unit seb_check u_seb_check (.*);
